// ===== src/d8fim_pkg.sv =====
// d8fim_pkg: shared types and the d8 inflow mask function for the flow inflow mask block
// no dependencies
`default_nettype none

package d8fim_pkg;

  localparam int unsigned DIR_W       = 8;
  localparam int unsigned SHIFT_ACROSS = 4;

  // esri d8 direction bits
  localparam logic [DIR_W-1:0] DIR_E  = 8'd1;
  localparam logic [DIR_W-1:0] DIR_SE = 8'd2;
  localparam logic [DIR_W-1:0] DIR_S  = 8'd4;
  localparam logic [DIR_W-1:0] DIR_SW = 8'd8;
  localparam logic [DIR_W-1:0] DIR_W_ = 8'd16;
  localparam logic [DIR_W-1:0] DIR_NW = 8'd32;
  localparam logic [DIR_W-1:0] DIR_N  = 8'd64;
  localparam logic [DIR_W-1:0] DIR_NE = 8'd128;

  typedef struct packed {
    logic [DIR_W-1:0] top;
    logic [DIR_W-1:0] mid;
    logic [DIR_W-1:0] bot;
  } col_t;

  typedef struct packed {
    logic [DIR_W-1:0] mask;
    logic             last;
  } res_t;

  // results made by one accepted item: none, one or two
  typedef struct packed {
    logic [1:0] cnt;
    res_t       res0;
    res_t       res1;
  } push_t;

  // inflow mask of the centre cell of c, with left column l and right column r
  function automatic logic [DIR_W-1:0] inflow(input col_t l, input col_t c, input col_t r);
    logic [DIR_W-1:0] m;
    m = '0;
    m |= (r.mid & DIR_W_) >> SHIFT_ACROSS;
    m |= (r.bot & DIR_NW) >> SHIFT_ACROSS;
    m |= (c.bot & DIR_N)  >> SHIFT_ACROSS;
    m |= (l.bot & DIR_NE) >> SHIFT_ACROSS;
    m |= (l.mid & DIR_E)  << SHIFT_ACROSS;
    m |= (l.top & DIR_SE) << SHIFT_ACROSS;
    m |= (c.top & DIR_S)  << SHIFT_ACROSS;
    m |= (r.top & DIR_SW) << SHIFT_ACROSS;
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== src/d8fim_if.sv =====
// d8fim_in_if / d8fim_out_if: valid-ready channels of the flow inflow mask block
// depends on nothing
`default_nettype none

interface d8fim_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] above_dir;
  logic [7:0] center_dir;
  logic [7:0] below_dir;
  logic       row_end;

  modport source (output valid, above_dir, center_dir, below_dir, row_end, input ready);
  modport sink   (input valid, above_dir, center_dir, below_dir, row_end, output ready);
endinterface

interface d8fim_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] inflow_mask;
  logic       last_of_row;

  modport source (output valid, inflow_mask, last_of_row, input ready);
  modport sink   (input valid, inflow_mask, last_of_row, output ready);
endinterface

`default_nettype wire

// ===== src/d8fim_window.sv =====
// d8fim_window: two-column window over the raster column stream, builds up to two masks per item
// depends on d8fim_pkg
`default_nettype none

module d8fim_window (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            acc,
  input  wire d8fim_pkg::col_t cur,
  input  wire logic            row_end,
  output d8fim_pkg::push_t     push
);
  import d8fim_pkg::*;

  col_t prev_r, prev_nxt;
  col_t pprev_r, pprev_nxt;
  logic has_prev_r, has_prev_nxt;
  res_t mid_res, end_res;

  always_comb begin
    mid_res.mask = inflow(pprev_r, prev_r, cur);
    mid_res.last = 1'b0;
    end_res.mask = inflow(prev_r, cur, '0);
    end_res.last = 1'b1;

    push = '0;
    if (acc) begin
      priority if (has_prev_r && row_end) begin
        push.cnt  = 2'd2;
        push.res0 = mid_res;
        push.res1 = end_res;
      end else if (has_prev_r) begin
        push.cnt  = 2'd1;
        push.res0 = mid_res;
      end else if (row_end) begin
        push.cnt  = 2'd1;
        push.res0 = end_res;
      end else begin
        // first column of a longer row makes nothing yet
        push.cnt  = 2'd0;
      end
    end

    prev_nxt     = prev_r;
    pprev_nxt    = pprev_r;
    has_prev_nxt = has_prev_r;
    if (acc) begin
      if (row_end) begin
        // row done: next row starts with a zero left column
        prev_nxt     = '0;
        pprev_nxt    = '0;
        has_prev_nxt = 1'b0;
      end else begin
        prev_nxt     = cur;
        pprev_nxt    = prev_r;
        has_prev_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r     <= '0;
      pprev_r    <= '0;
      has_prev_r <= 1'b0;
    end else begin
      prev_r     <= prev_nxt;
      pprev_r    <= pprev_nxt;
      has_prev_r <= has_prev_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/d8fim_outq.sv =====
// d8fim_outq: four-entry result queue, takes up to two results a cycle and gives one
// depends on d8fim_pkg
`default_nettype none

module d8fim_outq (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire d8fim_pkg::push_t push,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output d8fim_pkg::res_t       out_res
);
  import d8fim_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(DEPTH);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;
  logic             pop;

  assign out_valid = (count_r != '0);
  assign out_res   = mem[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two results from one item
  assign space     = (count_r <= (PTR_W+1)'(DEPTH - 2));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + (PTR_W+1)'(push.cnt) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr_r] <= push.res0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr_r + PTR_W'(1)] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/d8_flow_inflow_mask.sv =====
// d8_flow_inflow_mask: d8 inflow mask over a raster stream of three-cell columns
// output: each result is written to the result queue as the item completing it (next column, or row end) is accepted
// throughput: one item per cycle while the queue has room; a row-end item can make two results but
//   a row's first column makes none, so results keep pace with items and the four-entry result queue takes the burst
// reset: synchronous, active low; clears the column window and empties the queue
// depends on d8fim_pkg, d8fim_if, d8fim_window, d8fim_outq
`default_nettype none

module d8_flow_inflow_mask (
  input  wire logic  clk,
  input  wire logic  rst_n,
  d8fim_in_if.sink   in_ch,
  d8fim_out_if.source out_ch
);
  import d8fim_pkg::*;

  col_t  cur;
  push_t push;
  res_t  out_res;
  logic  space;
  logic  acc;

  assign cur.top      = in_ch.above_dir;
  assign cur.mid      = in_ch.center_dir;
  assign cur.bot      = in_ch.below_dir;
  assign in_ch.ready  = space;
  assign acc          = in_ch.valid && space;

  d8fim_window u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .cur     (cur),
    .row_end (in_ch.row_end),
    .push    (push)
  );

  d8fim_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .space     (space),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.inflow_mask = out_res.mask;
  assign out_ch.last_of_row = out_res.last;

endmodule

`default_nettype wire

// ===== src/d8fim_check.sv =====
// d8fim_check: port-level checks on the flow inflow mask block, bound to the top level
// depends on d8_flow_inflow_mask
`default_nettype none

module d8fim_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic in_row_end,
  input wire logic out_valid,
  input wire logic out_ready
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a row-end item always leaves at least one result behind
  a_row_end_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_row_end |=> out_valid)
    else $error("no result after row end");

  // an empty queue always has room
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with nothing pending");

  // nothing offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind d8_flow_inflow_mask d8fim_check u_d8fim_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_row_end (in_ch.row_end),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready)
);

`default_nettype wire
